// ----- hw/rtl/bval_pkg.sv -----
// Shared widths, constants and controller/datapath link types for the battery averager.
package bval_pkg;

  // Field widths
  localparam int MV_W   = 16;
  localparam int LVL_W  = 7;
  localparam int PROD_W = MV_W + LVL_W;

  // Percent scale
  localparam logic [LVL_W-1:0] FULL_PERCENT = 7'd100;
  localparam logic [LVL_W-1:0] ZERO_PERCENT = 7'd0;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_FULL  = 1'b0;
  localparam logic REG_EMPTY = 1'b1;

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted request
    logic update;      // apply clear or push to window state
    logic avg_zero;    // empty window, average is zero
    logic div_avg;     // start sum / count
    logic avg_take;    // store the average quotient
    logic lvl_eval;    // clamp test and scaled numerator
    logic div_lvl;     // start level division
    logic lvl_take;    // store the level quotient
    logic out_load;    // move results to output register
  } bval_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_clear;
    logic is_zero;
    logic cnt_zero;
    logic div_done;
    logic lvl_clamp;
  } bval_stat_t;

endpackage

// ----- hw/rtl/bval_if.sv -----
// Request and result channel interfaces for the battery averager.
interface bval_in_if;
  import bval_pkg::*;
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [MV_W-1:0] sample_millivolts;

  modport source (output valid, output req_type, output sample_millivolts, input ready);
  modport sink   (input valid, input req_type, input sample_millivolts, output ready);
endinterface

interface bval_out_if;
  import bval_pkg::*;
  logic             valid;
  logic             ready;
  logic [MV_W-1:0]  average_millivolts;
  logic [LVL_W-1:0] level_percent;

  modport source (output valid, output average_millivolts, output level_percent,
                  input ready);
  modport sink   (input valid, input average_millivolts, input level_percent,
                  output ready);
endinterface

// ----- hw/rtl/bval_regs.sv -----
// APB-style configuration registers holding the full and empty voltage thresholds.
module bval_regs
  import bval_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [MV_W-1:0]   full_mv,
  output logic [MV_W-1:0]   empty_mv
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Write thresholds on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      full_mv  <= MV_W'(4200);
      empty_mv <= MV_W'(3300);
    end else if (wr_en) begin
      if (reg_sel == REG_FULL) begin
        full_mv <= pwdata[MV_W-1:0];
      end else begin
        empty_mv <= pwdata[MV_W-1:0];
      end
    end
  end

  // Read back the selected threshold
  always_comb begin
    if (reg_sel == REG_FULL) begin
      prdata = DATA_W'(full_mv);
    end else begin
      prdata = DATA_W'(empty_mv);
    end
  end

endmodule

// ----- hw/rtl/bval_div.sv -----
// Restoring divider, one quotient bit per cycle.
module bval_div
  import bval_pkg::*;
#(
  parameter int N = 23
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [N-1:0]    dividend,
  input  logic [MV_W-1:0] divisor,
  output logic [N-1:0]    quotient,
  output logic            done
);

  localparam int CNT_W = (N > 1) ? $clog2(N) : 1;

  logic [MV_W-1:0]  rem;
  logic [MV_W-1:0]  dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MV_W:0]    trial;
  logic [MV_W:0]    diff;

  assign trial = {rem, quotient[N-1]};
  assign diff  = trial - {1'b0, dvs};

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
      cnt      <= CNT_W'(N - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (trial >= {1'b0, dvs}) begin
        rem      <= diff[MV_W-1:0];
        quotient <= {quotient[N-2:0], 1'b1};
      end else begin
        rem      <= trial[MV_W-1:0];
        quotient <= {quotient[N-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/bval_dp.sv -----
// Datapath: sample ring, running sum, fill count, level scaling and result register.
module bval_dp
  import bval_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  bval_cmd_t        cmd,
  output bval_stat_t       stat,
  input  logic             in_req_type,
  input  logic [MV_W-1:0]  in_mv,
  input  logic [MV_W-1:0]  full_mv,
  input  logic [MV_W-1:0]  empty_mv,
  output logic [MV_W-1:0]  out_avg,
  output logic [LVL_W-1:0] out_lvl
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = MV_W + CNT_W;
  localparam int DIV_N  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  logic [MV_W-1:0]   ring [WINDOW_DEPTH];
  logic [MV_W-1:0]   rd_data;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  fill;
  logic [SUM_W-1:0]  sum;
  logic              req_clear;
  logic [MV_W-1:0]   mv;
  logic [MV_W-1:0]   avg;
  logic [LVL_W-1:0]  lvl;
  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]   den;
  logic              win_full;
  logic [SUM_W-1:0]  drop;
  logic              div_start;
  logic [DIV_N-1:0]  div_a;
  logic [MV_W-1:0]   div_b;
  logic [DIV_N-1:0]  div_q;
  logic              div_done;
  logic              at_empty;
  logic              at_full;

  assign win_full = (fill == CNT_W'(WINDOW_DEPTH));
  assign drop     = win_full ? SUM_W'(rd_data) : '0;
  assign at_empty = (avg <= empty_mv);
  assign at_full  = (avg >= full_mv);

  assign stat.is_clear  = (req_clear == REQ_CLEAR);
  assign stat.is_zero   = (mv == '0);
  assign stat.cnt_zero  = (fill == '0);
  assign stat.div_done  = div_done;
  assign stat.lvl_clamp = at_empty || at_full;

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_clear <= in_req_type;
      mv        <= in_mv;
    end
  end

  // Ring memory: registered read at the write slot, write on push
  always_ff @(posedge clk) begin
    rd_data <= ring[slot];
    if (cmd.update && !stat.is_clear && !stat.is_zero) begin
      ring[slot] <= mv;
    end
  end

  // Window bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
      sum  <= '0;
    end else if (cmd.update) begin
      if (stat.is_clear) begin
        slot <= '0;
        fill <= '0;
        sum  <= '0;
      end else if (!stat.is_zero) begin
        sum <= sum - drop + SUM_W'(mv);
        if (!win_full) begin
          fill <= fill + 1'b1;
        end
        if (slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
    end
  end

  // Average and level results
  always_ff @(posedge clk) begin
    if (cmd.avg_zero) begin
      avg <= '0;
    end else if (cmd.avg_take) begin
      avg <= div_q[MV_W-1:0];
    end
    if (cmd.lvl_eval) begin
      if (at_empty) begin
        lvl <= ZERO_PERCENT;
      end else if (at_full) begin
        lvl <= FULL_PERCENT;
      end
      prod <= PROD_W'(avg - empty_mv) * PROD_W'(FULL_PERCENT);
      den  <= full_mv - empty_mv;
    end else if (cmd.lvl_take) begin
      lvl <= div_q[LVL_W-1:0];
    end
  end

  // Hold results for the output channel
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_avg <= avg;
      out_lvl <= lvl;
    end
  end

  // Shared divider operand select
  assign div_start = cmd.div_avg || cmd.div_lvl;
  always_comb begin
    if (cmd.div_lvl) begin
      div_a = DIV_N'(prod);
      div_b = den;
    end else begin
      div_a = DIV_N'(sum);
      div_b = MV_W'(fill);
    end
  end

  bval_div #(.N(DIV_N)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .done     (div_done)
  );

endmodule

// ----- hw/rtl/bval_ctrl.sv -----
// Controller: sequences one request through update, averaging, level and output.
module bval_ctrl
  import bval_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  bval_stat_t stat,
  output bval_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_UPDATE    = 3'd1;
  localparam logic [2:0] S_AVG       = 3'd2;
  localparam logic [2:0] S_AVG_WAIT  = 3'd3;
  localparam logic [2:0] S_LVL       = 3'd4;
  localparam logic [2:0] S_LVL_START = 3'd5;
  localparam logic [2:0] S_LVL_WAIT  = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_AVG;
      end
      S_AVG: begin
        if (stat.cnt_zero) begin
          cmd.avg_zero = 1'b1;
          state_next   = S_LVL;
        end else begin
          cmd.div_avg = 1'b1;
          state_next  = S_AVG_WAIT;
        end
      end
      S_AVG_WAIT: begin
        if (stat.div_done) begin
          cmd.avg_take = 1'b1;
          state_next   = S_LVL;
        end
      end
      S_LVL: begin
        cmd.lvl_eval = 1'b1;
        state_next   = stat.lvl_clamp ? S_DONE : S_LVL_START;
      end
      S_LVL_START: begin
        cmd.div_lvl = 1'b1;
        state_next  = S_LVL_WAIT;
      end
      S_LVL_WAIT: begin
        if (stat.div_done) begin
          cmd.lvl_take = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Raise result valid on load, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/battery_voltage_average_and_level.sv -----
// Battery voltage moving average with linear percent level: top level.
//
// Usage: each request on the item channel carries req_type and sample_millivolts.
// A clear request empties the averaging window; a nonzero sample enters a ring
// of WINDOW_DEPTH entries; a zero sample (failed read) leaves the window as is.
// Every request yields one result on the result channel: the integer mean of
// the window (0 when empty) and a 0..100 level, clamped at the empty and full
// thresholds written over the APB-style port (full at 0x0, empty at 0x4).
// One shared restoring divider of width N (23 bits for windows up to 127 entries)
// produces one quotient bit a cycle while busy, first for the mean, then the level.
// A clamped level skips the level division; an empty window skips both divisions.
// One request is processed at a time; the next is taken once the result is in
// the output register.
// The output register holds its result while the receiver stalls.
// Reset empties the window and loads the thresholds with 4200 mV and 3300 mV.
module battery_voltage_average_and_level
  import bval_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  bval_in_if.sink           item,
  bval_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  bval_cmd_t       cmd;
  bval_stat_t      stat;
  logic [MV_W-1:0] full_mv;
  logic [MV_W-1:0] empty_mv;

  bval_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .full_mv  (full_mv),
    .empty_mv (empty_mv)
  );

  bval_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bval_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (item.req_type),
    .in_mv       (item.sample_millivolts),
    .full_mv     (full_mv),
    .empty_mv    (empty_mv),
    .out_avg     (result.average_millivolts),
    .out_lvl     (result.level_percent)
  );

endmodule
